// ----- rtl/core/scbfa_pkg.sv -----
// package: payload types and constants for the size-class freelist allocator
package scbfa_pkg;

    localparam int ARENA_CHUNKS_DEF = 32;
    localparam int CHUNK_BYTES_DEF  = 32768;
    localparam int CLASS_COUNT_DEF  = 6;

    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 16;
    localparam int BATCH_W = 11;
    localparam int BAL_W   = 16;
    localparam int GRAIN_SHIFT = 6;
    localparam int NODE_W  = 15;   // granule + 1, zero means empty
    localparam int LINK_AW = 14;   // 16384 link entries
    localparam int BUMP_W  = 31;   // holds arena size up to 2^30 plus a class

    localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(8);

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_NO_MEM  = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } t_rsp;

endpackage

// ----- rtl/core/size_class_batched_freelist_allocator.sv -----
// top level: size-class allocator with local and global freelists and a bump arena
//
// usage
//   request channel: drive i_req and raise start while busy is low; one request
//   is taken per cycle where start is high and busy is low
//   result channel: o_rsp_valid pulses for one cycle with o_rsp; the receiver
//   cannot hold results off, so no stall is possible on that side
//   config channel: i_cfg_valid / o_cfg_ready carry batch_size; ready only
//   while idle; a write also reloads every class balance
// state sequences
//   a local-list hit keeps busy high through decode, link read issue, link
//   read data plus head update and result register; the strobe follows as
//   the block returns to idle; a plain free passes decode, free push and
//   result, an oversized request decode and result
//   a refill passes refill, global pop wait and local push per block taken
//   from the global list, refill and local push per bump block; a batch return
//   passes pop wait and return wait per block moved to the global list
//   busy is low while the strobe is up, so the next request can be taken at
//   the same edge that takes the result
// reset
//   synchronous active-low reset clears heads, bump pointer, chunk limit and
//   loads balances with 8; the link memory needs no clearing since a link is
//   always written before it can be read
module size_class_batched_freelist_allocator
    import scbfa_pkg::*;
#(
    parameter int ARENA_CHUNKS = ARENA_CHUNKS_DEF,
    parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF,
    parameter int CLASS_COUNT  = CLASS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_rsp_valid,
    output t_rsp               o_rsp,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [BATCH_W-1:0] i_cfg_data
);

    localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam logic [BUMP_W-1:0] CHUNK_B = BUMP_W'(CHUNK_BYTES);
    localparam logic [BUMP_W-1:0] ARENA_B = BUMP_W'(ARENA_CHUNKS * CHUNK_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ALLOC, S_REFILL, S_GPOP_WAIT, S_PUSH_LOCAL,
        S_POP_WAIT, S_RET_WAIT, S_FREE_PUSH, S_DONE
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [CW-1:0]       r_cls;
    logic [BATCH_W-1:0]  r_batch;
    logic [BATCH_W-1:0]  r_cnt;
    logic [NODE_W-1:0]   r_node;
    logic [NODE_W-1:0]   r_lhead [CLASS_COUNT];
    logic [NODE_W-1:0]   r_ghead [CLASS_COUNT];
    logic [BAL_W-1:0]    r_bal   [CLASS_COUNT];
    logic [BUMP_W-1:0]   r_bump;
    logic [BUMP_W-1:0]   r_limit;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    // link memory port
    logic                lk_we;
    logic [LINK_AW-1:0]  lk_waddr;
    logic [NODE_W-1:0]   lk_wdata;
    logic [LINK_AW-1:0]  lk_raddr;
    logic [NODE_W-1:0]   lk_rdata;

    scbfa_links u_links (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    // size to class: smallest class holding the size
    logic [CW-1:0] dec_cls;
    logic          dec_big;
    always_comb begin
        dec_cls = '0;
        dec_big = 1'b1;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (32'(r_req.request_size) <= (32'd64 << c)) begin
                dec_cls = CW'(c);
                dec_big = 1'b0;
            end
        end
    end

    logic [BATCH_W-1:0] half;
    assign half = (r_batch[BATCH_W-1:1] == '0) ? BATCH_W'(1) : (r_batch >> 1);

    logic [BUMP_W-1:0] cls_bytes;
    assign cls_bytes = BUMP_W'(64) << r_cls;

    logic [BAL_W-1:0] cur_bal;
    logic [NODE_W-1:0] cur_lh, cur_gh;
    assign cur_bal = r_bal[r_cls];
    assign cur_lh  = r_lhead[r_cls];
    assign cur_gh  = r_ghead[r_cls];

    function automatic logic [LINK_AW-1:0] node_idx(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] m;
        m = n - NODE_W'(1);
        return m[LINK_AW-1:0];
    endfunction

    // bump allocation for the refill step
    logic              bump_fits, bump_new_ok;
    logic [BUMP_W-1:0] bump_addr;
    always_comb begin
        bump_fits   = (r_bump + cls_bytes) <= r_limit;
        bump_new_ok = (cls_bytes <= CHUNK_B) && ((r_limit + CHUNK_B) <= ARENA_B);
        bump_addr   = bump_fits ? r_bump : r_limit;
    end

    // link port driving
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_raddr = '0;
        case (r_state)
            S_ALLOC:      lk_raddr = node_idx(cur_lh);
            S_REFILL:     lk_raddr = node_idx(cur_gh);
            S_DECODE:     lk_raddr = node_idx(cur_lh);
            S_POP_WAIT:   lk_raddr = node_idx(cur_lh);
            S_PUSH_LOCAL: begin
                lk_we    = 1'b1;
                lk_waddr = node_idx(r_node);
                lk_wdata = cur_lh;
            end
            S_RET_WAIT: begin
                lk_we    = 1'b1;
                lk_waddr = node_idx(cur_lh);
                lk_wdata = cur_gh;
            end
            S_FREE_PUSH: begin
                lk_we    = 1'b1;
                lk_waddr = r_req.block_address[ADDR_W-1 -: LINK_AW];
                lk_wdata = cur_lh;
            end
            default: ;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_batch     <= BATCH_RESET;
            r_bump      <= '0;
            r_limit     <= '0;
            r_rsp_valid <= 1'b0;
            r_cnt       <= '0;
            r_cls       <= '0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_lhead[c] <= '0;
                r_ghead[c] <= '0;
                r_bal[c]   <= BAL_W'(BATCH_RESET);
            end
        end else begin
            r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_DECODE;
                    end else if (i_cfg_valid) begin
                        r_batch <= i_cfg_data;
                        for (int c = 0; c < CLASS_COUNT; c++) begin
                            r_bal[c] <= BAL_W'(i_cfg_data);
                        end
                    end
                end
                S_DECODE: begin
                    r_cls <= dec_cls;
                    r_cnt <= '0;
                    if (dec_big) begin
                        r_rsp   <= '{granted_address: '0, status: ST_TOO_BIG};
                        r_state <= S_DONE;
                    end else if (!r_req.mode) begin
                        r_state <= (r_lhead[dec_cls] == '0) ? S_REFILL : S_ALLOC;
                    end else if (r_bal[dec_cls] == '0 || r_bal[dec_cls][BAL_W-1]) begin
                        r_state <= S_POP_WAIT;
                    end else begin
                        r_state <= S_FREE_PUSH;
                    end
                end
                // refill: one block per pass from global list or bump arena
                S_REFILL: begin
                    if (r_cnt == half) begin
                        r_state <= S_ALLOC;
                    end else if (cur_gh != '0) begin
                        r_node  <= cur_gh;
                        r_state <= S_GPOP_WAIT;
                    end else if (bump_fits || bump_new_ok) begin
                        if (!bump_fits) r_limit <= r_limit + CHUNK_B;
                        r_bump  <= bump_addr + cls_bytes;
                        r_node  <= NODE_W'(bump_addr[ADDR_W-1:GRAIN_SHIFT]) + NODE_W'(1);
                        r_state <= S_PUSH_LOCAL;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_GPOP_WAIT: begin
                    r_ghead[r_cls] <= lk_rdata;
                    r_state        <= S_PUSH_LOCAL;
                end
                S_PUSH_LOCAL: begin
                    r_lhead[r_cls] <= r_node;
                    r_bal[r_cls]   <= cur_bal - BAL_W'(1);
                    r_cnt          <= r_cnt + BATCH_W'(1);
                    r_state        <= S_REFILL;
                end
                // allocate pop: link read issued here, result next; an empty list answers no memory
                S_ALLOC: begin
                    if (cur_lh == '0) begin
                        r_rsp   <= '{granted_address: '0, status: ST_NO_MEM};
                        r_state <= S_DONE;
                    end else begin
                        r_node  <= cur_lh;
                        r_state <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: begin
                    if (!r_req.mode) begin
                        r_lhead[r_cls] <= lk_rdata;
                        r_bal[r_cls]   <= cur_bal + BAL_W'(1);
                        r_rsp <= '{granted_address: ADDR_W'({r_node - NODE_W'(1), 6'b0}),
                                   status: ST_DONE};
                        r_state <= S_DONE;
                    end else if (r_cnt == half || cur_lh == '0) begin
                        r_state <= S_FREE_PUSH;
                    end else begin
                        r_state <= S_RET_WAIT;
                    end
                end
                // batch return: move local head onto global list
                S_RET_WAIT: begin
                    r_ghead[r_cls] <= cur_lh;
                    r_lhead[r_cls] <= lk_rdata;
                    r_bal[r_cls]   <= cur_bal + BAL_W'(1);
                    r_cnt          <= r_cnt + BATCH_W'(1);
                    r_state        <= S_POP_WAIT;
                end
                S_FREE_PUSH: begin
                    r_lhead[r_cls] <= NODE_W'(r_req.block_address[ADDR_W-1 -: LINK_AW])
                                      + NODE_W'(1);
                    r_bal[r_cls]   <= cur_bal - BAL_W'(1);
                    r_rsp          <= '{granted_address: '0, status: ST_DONE};
                    r_state        <= S_DONE;
                end
                S_DONE: begin
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/scbfa_links.sv -----
// link store: one synchronous memory of next pointers, one read and one write port
module scbfa_links
    import scbfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [LINK_AW-1:0] i_waddr,
    input  logic [NODE_W-1:0]  i_wdata,
    input  logic [LINK_AW-1:0] i_raddr,
    output logic [NODE_W-1:0]  o_rdata
);

    logic [NODE_W-1:0] r_mem [2**LINK_AW];
    logic [NODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/scbfa_checker.sv -----
// checker: port-level properties of the allocator, bound to the top level
module scbfa_checker
    import scbfa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp,
    input logic o_cfg_ready
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted request did not raise busy");

    a_rsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid) else $error("result strobe longer than one cycle");

    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !busy) else $error("result while still busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_DONE |-> o_rsp.granted_address == '0)
        else $error("error result with nonzero address");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("config ready while busy");

endmodule

bind size_class_batched_freelist_allocator scbfa_checker u_scbfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp),
    .o_cfg_ready (o_cfg_ready)
);

// ----- verif/scbfa_checker.sv -----
// checker: watches the allocator channels, predicts each response and compares
module scbfa_scoreboard
    import scbfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  t_req               i_req,
    input  logic               o_rsp_valid,
    input  t_rsp               o_rsp,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [BATCH_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_rsp_count
);
    localparam int NCLS = CLASS_COUNT_DEF;
    localparam longint ARENA_BYTES = longint'(ARENA_CHUNKS_DEF) * CHUNK_BYTES_DEF;

    logic [BATCH_W-1:0]  batch_cur;
    logic [NODE_W-1:0]   loc_head [NCLS];
    logic [NODE_W-1:0]   glb_head [NCLS];
    logic [BAL_W-1:0]    balance  [NCLS];
    logic [NODE_W-1:0]   links    [1 << LINK_AW];
    longint              bump_ptr;
    longint              chunk_end;
    t_rsp                rsp_q [$];

    function automatic int unsigned half_batch();
        return (batch_cur / 2 == 0) ? 1 : batch_cur / 2;
    endfunction

    function automatic logic [NODE_W-1:0] to_node(logic [ADDR_W-1:0] a);
        return NODE_W'(a[ADDR_W-1:GRAIN_SHIFT]) + 1'b1;
    endfunction

    // pops the head of the global or local list of class c, returns the node
    function automatic logic [NODE_W-1:0] pop_node(bit from_glb, int c);
        logic [NODE_W-1:0] n;
        n = from_glb ? glb_head[c] : loc_head[c];
        if (from_glb) glb_head[c] = links[LINK_AW'(n - 1'b1)];
        else          loc_head[c] = links[LINK_AW'(n - 1'b1)];
        return n;
    endfunction

    function automatic void push_node(bit to_glb, int c, logic [NODE_W-1:0] n);
        links[LINK_AW'(n - 1'b1)] = to_glb ? glb_head[c] : loc_head[c];
        if (to_glb) glb_head[c] = n;
        else        loc_head[c] = n;
    endfunction

    // one block for class c from the global list or the bump arena, zero if none
    function automatic logic [NODE_W-1:0] fetch_block(int c);
        longint sz;
        longint a;
        sz = longint'(1) << (GRAIN_SHIFT + c);
        if (glb_head[c] != '0) return pop_node(1'b1, c);
        if (bump_ptr + sz > chunk_end) begin
            if (sz > CHUNK_BYTES_DEF) return '0;
            if (chunk_end + CHUNK_BYTES_DEF > ARENA_BYTES) return '0;
            bump_ptr = chunk_end;
            chunk_end += CHUNK_BYTES_DEF;
        end
        a = bump_ptr;
        bump_ptr += sz;
        return to_node(ADDR_W'(a));
    endfunction

    function automatic t_rsp predict_grant(t_req r);
        t_rsp res;
        int c;
        logic [NODE_W-1:0] n;
        res = '0;
        for (c = 0; c < NCLS; c++)
            if (r.request_size <= (32'd1 << (GRAIN_SHIFT + c))) break;
        if (c >= NCLS) begin
            res.status = ST_TOO_BIG;
            return res;
        end
        if (r.mode == 1'b0) begin
            if (loc_head[c] == '0) begin
                for (int i = 0; i < half_batch(); i++) begin
                    n = fetch_block(c);
                    if (n == '0) break;
                    push_node(1'b0, c, n);
                    balance[c] = balance[c] - 1'b1;
                end
            end
            if (loc_head[c] == '0) begin
                res.status = ST_NO_MEM;
                return res;
            end
            n = pop_node(1'b0, c);
            balance[c] = balance[c] + 1'b1;
            res.granted_address = ADDR_W'({n - 1'b1, 6'b0});
            return res;
        end
        // free: a nonpositive balance first returns up to half a batch
        if (balance[c] == '0 || balance[c][BAL_W-1]) begin
            for (int i = 0; i < half_batch() && loc_head[c] != '0; i++) begin
                n = pop_node(1'b0, c);
                balance[c] = balance[c] + 1'b1;
                push_node(1'b1, c, n);
            end
        end
        push_node(1'b0, c, to_node(r.block_address));
        balance[c] = balance[c] - 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_rsp_count = 0;
    end

    assign o_pending = rsp_q.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            batch_cur = BATCH_RESET;
            for (int c = 0; c < NCLS; c++) begin
                loc_head[c] = '0;
                glb_head[c] = '0;
                balance[c] = BAL_W'(BATCH_RESET);
            end
            bump_ptr = 0;
            chunk_end = 0;
            rsp_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                batch_cur = i_cfg_data;
                for (int c = 0; c < NCLS; c++) balance[c] = BAL_W'(i_cfg_data);
            end
            if (o_rsp_valid) begin
                o_rsp_count++;
                if (rsp_q.size() == 0) begin
                    report_mismatch("unexpected response", 1, 0);
                end else begin
                    want = rsp_q.pop_front();
                    if (o_rsp.granted_address !== want.granted_address)
                        report_mismatch("granted_address", o_rsp.granted_address,
                                        want.granted_address);
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", o_rsp.status, want.status);
                end
            end
            if (start && !busy) rsp_q.push_back(predict_grant(i_req));
        end
    end

endmodule

// ----- verif/tb_size_class_batched_freelist_allocator.sv -----
// testbench top: request stimulus, config phases and verdict for the allocator
module tb_size_class_batched_freelist_allocator;
    import scbfa_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_req               i_req = '0;
    logic               o_rsp_valid;
    t_rsp               o_rsp;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [BATCH_W-1:0] i_cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 rsp_count;
    int                 sent;
    // addresses handed out, reused as free targets
    logic [ADDR_W-1:0]  granted [$];

    always #1 i_clk = ~i_clk;

    size_class_batched_freelist_allocator i_dut (.*);

    scbfa_scoreboard i_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_rsp_valid, .o_rsp,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_rsp_count(rsp_count)
    );

    // remember granted addresses so frees can return real blocks
    always @(posedge i_clk)
        if (o_rsp_valid && o_rsp.status == ST_DONE && o_rsp.granted_address != '0)
            granted.push_back(o_rsp.granted_address);

    // one request, with a random gap before it unless no_gap is set; 'start' stays high only until taken
    task automatic send_request(logic m, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a,
                                bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        repeat (gap) @(posedge i_clk);
        i_req <= '{mode: m, request_size: sz, block_address: a};
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        sent++;
    endtask

    // wait for every expected response, plus slack for a trailing walk
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // write batch_size only while idle
    task automatic write_batch(logic [BATCH_W-1:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // class sizes: mostly small, sometimes exact class edges or oversized
    function automatic logic [SIZE_W-1:0] pick_size();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return SIZE_W'($urandom_range(1, 256));
        if (k < 7) return SIZE_W'(64 << $urandom_range(0, 5));
        if (k < 9) return SIZE_W'($urandom_range(1, 2048));
        return SIZE_W'($urandom_range(2049, 65535));
    endfunction

    // frees mostly return granted blocks, otherwise any address
    task automatic random_phase(int count, int alloc_pct);
        logic [ADDR_W-1:0] a;
        int idx;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < alloc_pct || granted.size() == 0) begin
                send_request(1'b0, pick_size(), ADDR_W'($urandom), i % 7 == 0);
            end else begin
                if ($urandom_range(0, 9) < 8) begin
                    idx = $urandom_range(0, granted.size() - 1);
                    a = granted[idx];
                    granted.delete(idx);
                    a = a | ADDR_W'($urandom_range(0, 63));   // unaligned most of the time
                end else begin
                    a = ADDR_W'($urandom);
                end
                send_request(1'b1, pick_size(), a, i % 7 == 0);
            end
        end
    endtask

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, class edges, oversize on both modes
        send_request(1'b0, 16'd0, '1, 1'b0);
        send_request(1'b0, 16'd1, '0, 1'b0);
        send_request(1'b0, 16'd64, '0, 1'b0);
        send_request(1'b0, 16'd65, '0, 1'b0);
        send_request(1'b0, 16'd2048, '0, 1'b0);
        send_request(1'b0, 16'd2049, '0, 1'b0);
        send_request(1'b0, 16'hFFFF, '1, 1'b0);
        send_request(1'b1, 16'hFFFF, '1, 1'b0);
        send_request(1'b1, 16'd64, 20'hFFFFF, 1'b0);
        send_request(1'b1, 16'd64, 20'h00041, 1'b0);
        send_request(1'b1, 16'd64, 20'h00041, 1'b0);   // repeated free
        for (int i = 0; i < 8; i++) send_request(1'b1, 16'd100, ADDR_W'(i * 128), 1'b1);
        for (int i = 0; i < 6; i++) send_request(1'b0, 16'd100, '0, 1'b0);

        // hold off until everything is back
        drain();

        // default batch, balanced mix
        random_phase(120, 55);

        // smallest batches: single-block transfers
        write_batch(11'd2);
        random_phase(80, 50);
        write_batch(11'd0);
        random_phase(40, 50);

        // largest batch drives the arena dry on big classes
        write_batch(11'h7FF);
        for (int i = 0; i < 12; i++) send_request(1'b0, 16'd2048, '0, 1'b0);
        random_phase(60, 80);

        write_batch(11'd5);
        random_phase(130, 45);

        drain();
        $display("covered %0d requests over batch sizes 8, 2, 0, 2047 and 5", sent);
        $display("%0d responses checked, %0d mismatches", rsp_count, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
